// ===== hdl/rckc_pkg.sv =====
// Shared codes, widths and the xorshift32 step of the rolling-code key checker.
package rckc_pkg;

	localparam int CODE_W = 32;
	localparam int CMD_W = 8;
	localparam int TMO_W = 16;
	localparam int OP_W = 2;
	localparam int ACT_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_MESSAGE = 2'd0;
	localparam logic [OP_W-1:0] OP_SYNC = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_OPEN = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_COMMAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_COMMAND = 2'd2;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [CMD_W-1:0] OPEN_RESET = 8'd1;
	localparam logic [CMD_W-1:0] CLOSE_RESET = 8'd2;

	typedef logic [CODE_W-1:0] code_t;

	function automatic code_t xorshift32(input code_t x);
		code_t a;
		code_t b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

// ===== hdl/rckc_window.sv =====
// Key window memory with per-entry valid bits and a registered read port.
module rckc_window
	import rckc_pkg::*;
#(
	parameter int KEY_COUNT = 10,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  code_t         wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output code_t         rd_data
);

	code_t mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] vld_q;
	code_t rd_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// An entry never written since reset reads as zero.
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hdl/rolling_code_key_checker.sv =====
// Top level of the rolling-code key checker: sequencer, mode state and result register.
//
// Items enter on req_valid/req_ready with operation, security_code and command_code.
// Each item yields exactly one result on rsp_valid/rsp_ready, held in an output
// register, so the next item can be accepted while a result still waits.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle, which the block itself does not enforce.
// One item is worked on at a time; req_ready is high only when the sequencer is idle.
// Start-sync, tick and unused-operation items go from the execute step straight to the
// response step, where the result is registered. A message in sync mode skips the scan
// and refills the window. A message in normal mode scans the key window one entry a cycle
// through the single read port of the window memory, and on a match regenerates the
// window through one xorshift32 unit, one entry a cycle.
// Reset clears the mode, timeout and door state, loads the configuration defaults and
// marks every window entry as zero; no clearing pass is needed.
// When the receiver stalls, the finished result waits in the output register and the
// sequencer holds in its last step until the register is free.
module rolling_code_key_checker
	import rckc_pkg::*;
#(
	parameter int KEY_COUNT = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [OP_W-1:0]       operation,
	input  logic [CODE_W-1:0]     security_code,
	input  logic [CMD_W-1:0]      command_code,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  key_accepted,
	output logic [ACT_W-1:0]      door_action,
	output logic                  sync_completed,
	output logic                  sync_active,
	output logic                  door_open,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int CW = $clog2(KEY_COUNT + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(KEY_COUNT - 1);
	localparam logic [CW-1:0] KEY_NUM = CW'(KEY_COUNT);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [2:0] state_q;
	logic [OP_W-1:0] op_q;
	code_t code_q;
	logic [CMD_W-1:0] cmd_q;
	code_t seed_q;
	logic [CW-1:0] idx_q;
	logic pend_s1;
	logic last_s1;

	logic sync_q;
	logic [TMO_W-1:0] timeout_q;
	logic door_q;
	logic [TMO_W-1:0] tmo_cfg_q;
	logic [CMD_W-1:0] open_cmd_q;
	logic [CMD_W-1:0] close_cmd_q;

	logic acc_q;
	logic [ACT_W-1:0] act_q;
	logic done_q;

	logic rsp_valid_q;
	logic rsp_acc_q;
	logic [ACT_W-1:0] rsp_act_q;
	logic rsp_done_q;
	logic rsp_sync_q;
	logic rsp_door_q;

	logic scan_issue;
	logic fill_en;
	logic hit;
	logic rsp_load;
	code_t next_seed;
	code_t rd_data;

	assign req_ready = (state_q == ST_IDLE);
	assign scan_issue = (state_q == ST_SCAN) && (idx_q < KEY_NUM) && !hit;
	assign fill_en = (state_q == ST_FILL);
	assign hit = (state_q == ST_SCAN) && pend_s1 && (rd_data == code_q);
	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);
	assign next_seed = xorshift32(seed_q);

	rckc_window #(
		.KEY_COUNT(KEY_COUNT),
		.AW(AW)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(fill_en),
		.wr_addr(idx_q[AW-1:0]),
		.wr_data(next_seed),
		.rd_en(scan_issue),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_cfg_q <= TIMEOUT_RESET;
			open_cmd_q <= OPEN_RESET;
			close_cmd_q <= CLOSE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_TIMEOUT: tmo_cfg_q <= cfg_data;
				REG_OPEN_COMMAND: open_cmd_q <= cfg_data[CMD_W-1:0];
				REG_CLOSE_COMMAND: close_cmd_q <= cfg_data[CMD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			op_q <= operation;
			code_q <= security_code;
			cmd_q <= command_code;
		end
		if (state_q == ST_EXEC || hit) begin
			seed_q <= code_q;
		end else if (fill_en) begin
			seed_q <= next_seed;
		end
		if (scan_issue) begin
			last_s1 <= (idx_q == LAST_IDX);
		end
		if (rsp_load) begin
			rsp_acc_q <= acc_q;
			rsp_act_q <= act_q;
			rsp_done_q <= done_q;
			rsp_sync_q <= sync_q;
			rsp_door_q <= door_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			pend_s1 <= 1'b0;
			sync_q <= 1'b0;
			timeout_q <= '0;
			door_q <= 1'b0;
			acc_q <= 1'b0;
			act_q <= ACT_NONE;
			done_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= scan_issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						acc_q <= 1'b0;
						act_q <= ACT_NONE;
						done_q <= 1'b0;
						idx_q <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
					case (op_q)
						OP_MESSAGE: begin
							if (sync_q) begin
								sync_q <= 1'b0;
								timeout_q <= '0;
								done_q <= 1'b1;
								state_q <= ST_FILL;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						OP_SYNC: begin
							sync_q <= 1'b1;
							timeout_q <= tmo_cfg_q;
						end
						OP_TICK: begin
							if (sync_q) begin
								if (timeout_q <= TMO_W'(1)) begin
									timeout_q <= '0;
									sync_q <= 1'b0;
								end else begin
									timeout_q <= timeout_q - TMO_W'(1);
								end
							end
						end
						default: ;
					endcase
				end
				ST_SCAN: begin
					if (hit) begin
						acc_q <= 1'b1;
						if (cmd_q == open_cmd_q) begin
							door_q <= 1'b1;
							act_q <= ACT_OPEN;
						end else if (cmd_q == close_cmd_q) begin
							door_q <= 1'b0;
							act_q <= ACT_CLOSE;
						end
						idx_q <= '0;
						state_q <= ST_FILL;
					end else begin
						if (scan_issue) begin
							idx_q <= idx_q + CW'(1);
						end
						if (pend_s1 && last_s1) begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_FILL: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_RESP;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign key_accepted = rsp_acc_q;
	assign door_action = rsp_act_q;
	assign sync_completed = rsp_done_q;
	assign sync_active = rsp_sync_q;
	assign door_open = rsp_door_q;

	a_action_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_act_q != ACT_NONE) |-> rsp_acc_q)
		else $error("door action reported without an accepted key");

	a_sync_not_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_done_q |-> !rsp_acc_q && !rsp_sync_q)
		else $error("sync load reported together with acceptance or sync mode");

	a_timeout_in_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(timeout_q != '0) |-> sync_q)
		else $error("timeout running outside sync mode");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (idx_q < KEY_NUM))
		else $error("window fill index out of range");

endmodule
